// ===== hw/rtl/bounding_sphere_grow_macros.svh =====
// Assertion macros shared by the bounding sphere RTL.
`ifndef BOUNDING_SPHERE_GROW_MACROS_SVH
`define BOUNDING_SPHERE_GROW_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define BSG_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication between a trigger and a consequence in the same cycle.
`define BSG_ASSERT_IMPL(lbl, trig, cons, msg) \
  `BSG_ASSERT_CLK(lbl, (trig) |-> (cons), msg)

`endif

// ===== hw/rtl/bsg_pkg.sv =====
// Types and constants of the bounding sphere grow block.
package bsg_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_SPHERE = 2'd2
  } cmd_e;

  // Width of one lane operand: magnitudes, distances and scale factors.
  localparam int unsigned LANE_W = 34;
  // Width of a lane product and of the sum of squares.
  localparam int unsigned PROD_W = 2 * LANE_W;
  // Width of the square root remainder.
  localparam int unsigned SREM_W = LANE_W + 2;

  localparam logic [30:0] RADIUS_MAX = 31'h7FFF_FFFF;

endpackage

// ===== hw/rtl/bounding_sphere_grow.sv =====
// Top level: running bounding sphere grown by points and spheres, bit-serial datapath.
// Clear, empty, equal-center and unused commands go from accept straight to the result;
// an input inside the sphere, or a sphere that holds it, ends after the square root.
// All others run four 34-step bit-serial passes: squaring, square root, scale multiply
// and division; all but the root use three shared lanes, and one item is in work at a time.
// Reset (rst_ni low, asynchronous) empties the sphere and drops the output valid.
`include "bounding_sphere_grow_macros.svh"

module bounding_sphere_grow (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // in_x[31:0], in_y[63:32], in_z[95:64], in_radius[126:96], zero [127]
  input  logic [127:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], radius_out[126:96], grew[127]
  output logic [127:0] m_axis_tdata
);

  localparam int unsigned LW = bsg_pkg::LANE_W;
  localparam int unsigned PW = bsg_pkg::PROD_W;
  localparam int unsigned SW = bsg_pkg::SREM_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQR, ST_SUMA, ST_SUMB, ST_SQRT, ST_EVAL, ST_MUL, ST_DIV, ST_MOVE, ST_DONE
  } state_e;

  state_e state_q;
  logic [5:0] cnt_q;
  logic cnt_last;

  // Sphere state.
  logic [31:0] cx_q, cy_q, cz_q;
  logic [30:0] r_q;

  // Output register.
  logic        m_valid_q;
  logic [31:0] ox_q, oy_q, oz_q;
  logic [30:0] or_q;
  logic        grew_q;

  // Item registers and datapath.
  bsg_pkg::cmd_e cmd_q;
  logic [31:0] px_q, py_q, pz_q;
  logic [30:0] pr_q;
  logic [31:0] nx_q, ny_q, nz_q;
  logic [30:0] nr_q;
  logic [PW-1:0] lane_q [3];
  logic [LW-1:0] mag_q [3];
  logic          neg_q [3];
  logic [PW-1:0] n_q;
  logic [LW-1:0] root_q;
  logic [SW-1:0] srem_q;

  logic accept, out_free;
  bsg_pkg::cmd_e in_cmd;
  logic [31:0] in_x, in_y, in_z;
  logic [30:0] in_r;

  assign in_cmd = bsg_pkg::cmd_e'(s_axis_tuser);
  assign in_x   = s_axis_tdata[31:0];
  assign in_y   = s_axis_tdata[63:32];
  assign in_z   = s_axis_tdata[95:64];
  assign in_r   = s_axis_tdata[126:96];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign cnt_last      = (cnt_q == 6'(LW - 1));

  // Decision at accept: trivial commands finish at once.
  logic        fast_slow;
  logic [31:0] fast_x, fast_y, fast_z;
  logic [30:0] fast_r;
  logic        sph_empty, in_empty, same_center;

  assign sph_empty   = (r_q == '0) && (cx_q == '0) && (cy_q == '0) && (cz_q == '0);
  assign in_empty    = (in_r == '0) && (in_x == '0) && (in_y == '0) && (in_z == '0);
  assign same_center = (cx_q == in_x) && (cy_q == in_y) && (cz_q == in_z);

  always_comb begin
    fast_slow = 1'b0;
    fast_x = cx_q;
    fast_y = cy_q;
    fast_z = cz_q;
    fast_r = r_q;
    case (in_cmd)
      bsg_pkg::CMD_CLEAR: begin
        fast_x = '0;
        fast_y = '0;
        fast_z = '0;
        fast_r = '0;
      end
      bsg_pkg::CMD_POINT: begin
        if (sph_empty) begin
          fast_x = in_x;
          fast_y = in_y;
          fast_z = in_z;
          fast_r = '0;
        end else begin
          fast_slow = 1'b1;
        end
      end
      bsg_pkg::CMD_SPHERE: begin
        if (in_empty) begin
          fast_slow = 1'b0;
        end else if (sph_empty) begin
          fast_x = in_x;
          fast_y = in_y;
          fast_z = in_z;
          fast_r = in_r;
        end else if (same_center) begin
          if (in_r > r_q) begin
            fast_r = in_r;
          end
        end else begin
          fast_slow = 1'b1;
        end
      end
      default: begin
        fast_slow = 1'b0;
      end
    endcase
  end

  // Per-lane component differences: old center minus point, or input minus old center.
  logic [32:0] diff [3];
  logic [32:0] dmag [3];
  logic [31:0] c_sel [3];
  logic [31:0] p_sel [3];

  assign c_sel[0] = cx_q;
  assign c_sel[1] = cy_q;
  assign c_sel[2] = cz_q;
  assign p_sel[0] = in_x;
  assign p_sel[1] = in_y;
  assign p_sel[2] = in_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (in_cmd == bsg_pkg::CMD_SPHERE) begin
        diff[i] = {p_sel[i][31], p_sel[i]} - {c_sel[i][31], c_sel[i]};
      end else begin
        diff[i] = {c_sel[i][31], c_sel[i]} - {p_sel[i][31], p_sel[i]};
      end
      dmag[i] = diff[i][32] ? (~diff[i] + 33'd1) : diff[i];
    end
  end

  // Lane arithmetic: shift-add multiply step and restoring divide step.
  logic [LW:0]   mul_sum [3];
  logic [LW:0]   div_t   [3];
  logic [LW:0]   div_r   [3];
  logic          div_ge  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mul_sum[i] = {1'b0, lane_q[i][PW-1:LW]} + {1'b0, mag_q[i]};
      div_t[i]   = {lane_q[i][PW-1:LW], lane_q[i][LW-1]};
      div_ge[i]  = (div_t[i] >= {1'b0, root_q});
      div_r[i]   = div_t[i] - {1'b0, root_q};
    end
  end

  // Square root step, two bits of the sum of squares per cycle.
  logic [SW+1:0] sq_t, sq_trial, sq_diff;
  logic          sq_ge;

  assign sq_t     = {srem_q, n_q[PW-1:PW-2]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = (sq_t >= sq_trial);
  assign sq_diff  = sq_t - sq_trial;

  // Evaluation once the distance is known; root_q holds it.
  logic          pt_grow;
  logic [LW:0]   pt_sum;
  logic [LW-1:0] pt_k;
  logic [LW+1:0] sp_sum, sp_sum1;
  logic          sp_inside, sp_holds;
  logic [LW-1:0] sp_k, sp_step;
  logic          ev_move;
  logic [LW-1:0] ev_k, ev_scale;

  assign pt_grow   = (root_q > {3'b000, r_q});
  assign pt_sum    = {1'b0, root_q} + {4'b0000, r_q} + 35'd1;
  assign pt_k      = pt_sum[LW:1];
  assign sp_sum    = {2'b00, root_q} + {5'b00000, r_q} + {5'b00000, pr_q};
  assign sp_sum1   = sp_sum + 36'd1;
  assign sp_inside = (sp_sum <= {4'b0000, r_q, 1'b0});
  assign sp_holds  = (sp_sum <= {4'b0000, pr_q, 1'b0});
  assign sp_k      = sp_sum1[LW:1];
  assign sp_step   = sp_k - {3'b000, r_q};

  always_comb begin
    if (cmd_q == bsg_pkg::CMD_POINT) begin
      ev_move  = pt_grow;
      ev_k     = pt_k;
      ev_scale = pt_k;
    end else begin
      ev_move  = !sp_inside && !sp_holds;
      ev_k     = sp_k;
      ev_scale = sp_step;
    end
  end

  // Control, sphere state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      cz_q      <= '0;
      r_q       <= '0;
      m_valid_q <= 1'b0;
      ox_q      <= '0;
      oy_q      <= '0;
      oz_q      <= '0;
      or_q      <= '0;
      grew_q    <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            state_q <= fast_slow ? ST_SQR : ST_DONE;
          end
        end
        ST_SQR: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            state_q <= ST_SUMA;
          end
        end
        ST_SUMA: begin
          state_q <= ST_SUMB;
        end
        ST_SUMB: begin
          cnt_q   <= '0;
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          cnt_q   <= '0;
          state_q <= ev_move ? ST_MUL : ST_DONE;
        end
        ST_MUL: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 6'd1;
          if (cnt_last) begin
            state_q <= ST_MOVE;
          end
        end
        ST_MOVE: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            cx_q      <= nx_q;
            cy_q      <= ny_q;
            cz_q      <= nz_q;
            r_q       <= nr_q;
            ox_q      <= nx_q;
            oy_q      <= ny_q;
            oz_q      <= nz_q;
            or_q      <= nr_q;
            grew_q    <= (nx_q != cx_q) || (ny_q != cy_q) || (nz_q != cz_q) || (nr_q != r_q);
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_q <= in_cmd;
          px_q  <= in_x;
          py_q  <= in_y;
          pz_q  <= in_z;
          pr_q  <= in_r;
          nx_q  <= fast_x;
          ny_q  <= fast_y;
          nz_q  <= fast_z;
          nr_q  <= fast_r;
          for (int i = 0; i < 3; i++) begin
            mag_q[i]  <= {1'b0, dmag[i]};
            neg_q[i]  <= diff[i][32];
            lane_q[i] <= {{LW{1'b0}}, 1'b0, dmag[i]};
          end
        end
      end
      ST_SQR, ST_MUL: begin
        for (int i = 0; i < 3; i++) begin
          if (lane_q[i][0]) begin
            lane_q[i] <= {mul_sum[i], lane_q[i][LW-1:1]};
          end else begin
            lane_q[i] <= {1'b0, lane_q[i][PW-1:1]};
          end
        end
      end
      ST_SUMA: begin
        n_q <= lane_q[0] + lane_q[1];
      end
      ST_SUMB: begin
        n_q    <= n_q + lane_q[2];
        root_q <= '0;
        srem_q <= '0;
      end
      ST_SQRT: begin
        n_q <= {n_q[PW-3:0], 2'b00};
        if (sq_ge) begin
          srem_q <= sq_diff[SW-1:0];
          root_q <= {root_q[LW-2:0], 1'b1};
        end else begin
          srem_q <= sq_t[SW-1:0];
          root_q <= {root_q[LW-2:0], 1'b0};
        end
      end
      ST_EVAL: begin
        if (cmd_q == bsg_pkg::CMD_POINT) begin
          nx_q <= px_q;
          ny_q <= py_q;
          nz_q <= pz_q;
        end else begin
          nx_q <= cx_q;
          ny_q <= cy_q;
          nz_q <= cz_q;
        end
        if (ev_move) begin
          nr_q <= (ev_k > {3'b000, bsg_pkg::RADIUS_MAX}) ? bsg_pkg::RADIUS_MAX : ev_k[30:0];
        end else if (cmd_q == bsg_pkg::CMD_SPHERE && !sp_inside) begin
          // The input sphere holds the current one and replaces it.
          nx_q <= px_q;
          ny_q <= py_q;
          nz_q <= pz_q;
          nr_q <= pr_q;
        end else begin
          // The input already lies inside: the sphere stays as it is.
          nx_q <= cx_q;
          ny_q <= cy_q;
          nz_q <= cz_q;
          nr_q <= r_q;
        end
        for (int i = 0; i < 3; i++) begin
          lane_q[i] <= {{LW{1'b0}}, ev_scale};
        end
      end
      ST_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (div_ge[i]) begin
            lane_q[i] <= {div_r[i][LW-1:0], lane_q[i][LW-2:0], 1'b1};
          end else begin
            lane_q[i] <= {div_t[i][LW-1:0], lane_q[i][LW-2:0], 1'b0};
          end
        end
      end
      ST_MOVE: begin
        nx_q <= neg_q[0] ? nx_q - lane_q[0][31:0] : nx_q + lane_q[0][31:0];
        ny_q <= neg_q[1] ? ny_q - lane_q[1][31:0] : ny_q + lane_q[1][31:0];
        nz_q <= neg_q[2] ? nz_q - lane_q[2][31:0] : nz_q + lane_q[2][31:0];
      end
      default: begin
        n_q <= n_q;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {grew_q, or_q, oz_q, oy_q, ox_q};

  `BSG_ASSERT_IMPL(a_div_rem_below, state_q == ST_DIV, lane_q[0][PW-1:LW] < root_q, "divide remainder not below divisor")
  `BSG_ASSERT_IMPL(a_div_nonzero, state_q == ST_MUL || state_q == ST_DIV, root_q != '0, "zero distance in move")
  `BSG_ASSERT_CLK(a_sphere_hold, state_q != ST_DONE |=> $stable(r_q) && $stable(cx_q), "sphere changed outside commit")
  `BSG_ASSERT_CLK(a_valid_from_done, $rose(m_valid_q) |-> $past(state_q) == ST_DONE, "result without commit")

endmodule

// ===== dv/bounding_sphere_grow_tb.sv =====
// Self-checking testbench for the bounding sphere grow block: directed table, then random items.
`timescale 1ns / 1ps

module bounding_sphere_grow_tb;

  typedef struct packed {
    logic [30:0] r;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } geom_t;

  typedef struct packed {
    logic        grew;
    logic [30:0] r;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } sphere_t;

  typedef struct {
    logic [1:0] cmd;
    geom_t      g;
    logic       known;
    sphere_t    res;
  } row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;

  bounding_sphere_grow dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predicted sphere state.
  longint     cen_x, cen_y, cen_z;
  longint     rad;
  sphere_t    sphere_q[$];
  int         mismatches = 0;
  bit         hold_off = 0;
  int         rx_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Floor square root of the exact sum of squares (up to 66 bits).
  function automatic longint unsigned span3(longint dx, longint dy, longint dz);
    logic [127:0] n, c2;
    logic [63:0]  res, c;
    n = abs64(dx) * abs64(dx);
    n = n + 128'(abs64(dy)) * abs64(dy) + 128'(abs64(dz)) * abs64(dz);
    res = 0;
    for (int b = 34; b >= 0; b--) begin
      c = res | (64'd1 << b);
      c2 = 128'(c) * c;
      if (c2 <= n) res = c;
    end
    return res;
  endfunction

  function automatic longint shift_toward(longint base, longint delta,
                                          longint unsigned k, longint unsigned d);
    logic [127:0] p;
    longint       off;
    if (d == 0) return base;
    p = 128'(abs64(delta)) * k;
    off = longint'(p / d);
    return delta < 0 ? base - off : base + off;
  endfunction

  function automatic longint sat31(longint unsigned v);
    return v > 64'h7FFF_FFFF ? 64'h7FFF_FFFF : v;
  endfunction

  function automatic sphere_t grow_sphere(logic [1:0] cmd, geom_t g);
    longint px, py, pz, pr, ox, oy, oz, orr, dx, dy, dz;
    longint unsigned len, k, s;
    sphere_t o;
    px = longint'($signed(g.x)); py = longint'($signed(g.y)); pz = longint'($signed(g.z));
    pr = g.r;
    ox = cen_x; oy = cen_y; oz = cen_z; orr = rad;
    if (cmd == bsg_pkg::CMD_CLEAR) begin
      cen_x = 0; cen_y = 0; cen_z = 0; rad = 0;
    end else if (cmd == bsg_pkg::CMD_POINT) begin
      if (rad == 0 && cen_x == 0 && cen_y == 0 && cen_z == 0) begin
        cen_x = px; cen_y = py; cen_z = pz;
      end else begin
        dx = cen_x - px; dy = cen_y - py; dz = cen_z - pz;
        len = span3(dx, dy, dz);
        if (len > rad) begin
          k = (len + rad + 1) >> 1;
          cen_x = shift_toward(px, dx, k, len);
          cen_y = shift_toward(py, dy, k, len);
          cen_z = shift_toward(pz, dz, k, len);
          rad = sat31(k);
        end
      end
    end else if (cmd == bsg_pkg::CMD_SPHERE) begin
      if (pr == 0 && px == 0 && py == 0 && pz == 0) begin
      end else if (rad == 0 && cen_x == 0 && cen_y == 0 && cen_z == 0) begin
        cen_x = px; cen_y = py; cen_z = pz; rad = pr;
      end else if (cen_x == px && cen_y == py && cen_z == pz) begin
        if (pr > rad) rad = pr;
      end else begin
        dx = px - cen_x; dy = py - cen_y; dz = pz - cen_z;
        len = span3(dx, dy, dz);
        s = rad + len + pr;
        if (s <= 2 * rad) begin
        end else if (s <= 2 * pr) begin
          cen_x = px; cen_y = py; cen_z = pz; rad = pr;
        end else begin
          k = (s + 1) >> 1;
          cen_x = shift_toward(cen_x, dx, k - rad, len);
          cen_y = shift_toward(cen_y, dy, k - rad, len);
          cen_z = shift_toward(cen_z, dz, k - rad, len);
          rad = sat31(k);
        end
      end
    end
    o.x = cen_x[31:0]; o.y = cen_y[31:0]; o.z = cen_z[31:0]; o.r = rad[30:0];
    o.grew = (cen_x != ox || cen_y != oy || cen_z != oz || rad != orr);
    return o;
  endfunction

  task automatic send_item(logic [1:0] cmd, geom_t g);
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {1'b0, g};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic gap(int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    sphere_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      rx_count++;
      if (sphere_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = sphere_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.r !== want.r || got.grew !== want.grew) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h r=%h g=%b, got x=%h y=%h z=%h r=%h g=%b",
                     want.x, want.y, want.z, want.r, want.grew,
                     got.x, got.y, got.z, got.r, got.grew);
        end
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk_i);
        hold_off = 0;
      end
      if ((rx_count / 64) % 3 == 1) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 8;
      default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 4;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 5))
      0:       return 31'($urandom);
      1:       return bsg_pkg::RADIUS_MAX;
      2:       return 31'd0;
      default: return 31'($urandom_range(0, 3_000_000));
    endcase
  endfunction

  row_t directed[$];

  function automatic row_t mk(logic [1:0] c, logic [31:0] x, logic [31:0] y,
                               logic [31:0] z, logic [30:0] r,
                               logic known = 0, sphere_t res = '0);
    row_t w;
    w.cmd = c; w.g = '{r: r, z: z, y: y, x: x}; w.known = known; w.res = res;
    return w;
  endfunction

  initial begin
    sphere_t want;
    geom_t   g;
    logic [1:0] c;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = bsg_pkg::CMD_CLEAR;
    cen_x = 0; cen_y = 0; cen_z = 0; rad = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty sphere after reset, extremes, and the unused command.
    directed.push_back(mk(bsg_pkg::CMD_POINT, 0, 0, 0, 0, 1, '0));
    directed.push_back(mk(2'd3, 5, 5, 5, 5, 1, '0));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 0, 0, 0, 0, 1, '0));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h10000, 0, 0, bsg_pkg::RADIUS_MAX, 1,
                          '{grew: 1, r: bsg_pkg::RADIUS_MAX, z: 0, y: 0, x: 32'h10000}));
    directed.push_back(mk(bsg_pkg::CMD_CLEAR, 1, 2, 3, 4, 1, '{grew: 1, default: 0}));
    directed.push_back(mk(bsg_pkg::CMD_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
    directed.push_back(mk(bsg_pkg::CMD_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
    directed.push_back(mk(bsg_pkg::CMD_POINT, 0, 0, 0, 0));
    directed.push_back(mk(2'd3, 0, 0, 0, 0));
    directed.push_back(mk(bsg_pkg::CMD_CLEAR, 0, 0, 0, 0));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h100000, 32'h20000, 0, 32'h30000));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h100000, 32'h20000, 0, 32'h10000));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h100000, 32'h20000, 0, 32'h50000));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h110000, 32'h20000, 0, 32'h10000));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h120000, 32'h20000, 0, 32'h900000));
    directed.push_back(mk(bsg_pkg::CMD_POINT, 32'h120000, 32'h20000, 0, 0));
    directed.push_back(mk(bsg_pkg::CMD_POINT, 32'hF000_0000, 32'h1000_0000, 32'h0800_0000, 0));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                          bsg_pkg::RADIUS_MAX));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                          bsg_pkg::RADIUS_MAX));
    directed.push_back(mk(bsg_pkg::CMD_SPHERE, 0, 0, 0, 0));
    directed.push_back(mk(bsg_pkg::CMD_CLEAR, 0, 0, 0, 0));

    foreach (directed[i]) begin
      want = grow_sphere(directed[i].cmd, directed[i].g);
      if (directed[i].known && want !== directed[i].res) begin
        mismatches++;
        $display("table row %0d disagrees with prediction", i);
      end
      sphere_q.push_back(directed[i].known ? directed[i].res : want);
      send_item(directed[i].cmd, directed[i].g);
    end

    // Random part: mostly enclose commands, occasional clears and unused codes.
    for (int n = 0; n < 1530; n++) begin
      if (n == 300) hold_off = 1;
      if (n == 800) begin
        gap(1);
        wait (sphere_q.size() == 0);
        @(negedge clk_i);
      end
      case ($urandom_range(0, 39))
        0:       c = bsg_pkg::CMD_CLEAR;
        1:       c = 2'd3;
        default: c = $urandom_range(0, 1) ? bsg_pkg::CMD_POINT : bsg_pkg::CMD_SPHERE;
      endcase
      g.x = rand_coord(); g.y = rand_coord(); g.z = rand_coord(); g.r = rand_radius();
      sphere_q.push_back(grow_sphere(c, g));
      send_item(c, g);
      if ($urandom_range(0, 3) == 0) gap($urandom_range(1, 200));
    end
    s_axis_tvalid <= 1'b0;

    wait (sphere_q.size() == 0);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
